>>> rtl/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

   localparam int MAX_PAGES = 131072;
   localparam int WORD_BITS = 64;
   localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = $clog2(MAP_WORDS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int PAGE_W    = 17;
   localparam int CNT_W     = 18;
   localparam int STAT_W    = 3;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_INIT  = 3'd2;
   localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NO_CHANGE = 3'd4;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RUN     = 2'd1;
   localparam logic [1:0] OP_FREE    = 2'd2;
   localparam logic [1:0] OP_RESERVE = 2'd3;

   localparam logic [2:0] REG_TOTAL = 3'd0;

   typedef enum logic [8:0] {
      S_INIT = 9'b000000001,
      S_IDLE = 9'b000000010,
      S_SRD  = 9'b000000100,
      S_SBIT = 9'b000001000,
      S_MRD  = 9'b000010000,
      S_MWR  = 9'b000100000,
      S_PRD  = 9'b001000000,
      S_PWR  = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

endpackage

>>> rtl/bitmap_page_allocator_core.sv
`timescale 1ns / 1ps
// First-fit page allocator over a used/free bitmap held in one word memory.
// Request channel (req_valid / req_stall): op, page, count. One request is
// taken at a time; req_stall is high while a request is in progress.
// Result channel (rsp_valid / rsp_stall): status, first page, free count,
// used count, one result per request, held in an output register. The next
// request may be taken while a result still waits; that request finishes
// its work and then waits in its final step until the output register frees.
// Steps: free and reserve read the page's word (S_PRD), write it back (S_PWR)
// and load the result register from S_DONE; refused requests (not initialised,
// out of range, zero-count run) go straight to S_DONE. Allocation scans from
// page 0: a fully used word, or a fully free word that stays inside the run,
// is passed whole after its read; otherwise each page bit is tested in turn;
// then each word of the run is read and marked used (S_MRD, S_MWR) before
// S_DONE loads the result. The next request can be taken the cycle after its predecessor's result is loaded.
// After reset the bitmap is filled with ones (all pages used), one word a
// cycle over all 2048 words; no request is taken meanwhile, configuration
// writes are. The page total is written over the APB port at address 0.
module bitmap_page_allocator_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [bpa_pkg::PAGE_W-1:0]   req_page,
   input  logic [bpa_pkg::CNT_W-1:0]    req_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bpa_pkg::STAT_W-1:0]   rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]   rsp_first_page,
   output logic [bpa_pkg::CNT_W-1:0]    rsp_free_count,
   output logic [bpa_pkg::CNT_W-1:0]    rsp_used_count,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam int WB = bpa_pkg::WORD_BITS;
   localparam int AW = bpa_pkg::WADDR_W;
   localparam int BW = bpa_pkg::BIT_W;
   localparam int PW = bpa_pkg::PAGE_W;
   localparam int CW = bpa_pkg::CNT_W;

   logic [WB-1:0] mem [bpa_pkg::MAP_WORDS];
   logic [WB-1:0] rdata_ff;

   bpa_pkg::state_type state_ff, state_in;
   logic [AW-1:0]  init_ff, init_in;
   logic [CW-1:0]  total_ff;
   logic [CW-1:0]  free_ff, free_in;
   logic [1:0]     op_ff, op_in;
   logic [PW-1:0]  page_ff, page_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [CW-1:0]  run_ff, run_in;
   logic [PW-1:0]  first_ff, first_in;
   logic [PW-1:0]  last_ff, last_in;
   logic [AW-1:0]  mw_ff, mw_in;
   logic [bpa_pkg::STAT_W-1:0] st_ff, st_in;
   logic [PW-1:0]  start_ff, start_in;
   logic           rv_ff, rv_in;
   logic [bpa_pkg::STAT_W-1:0] ost_ff, ost_in;
   logic [PW-1:0]  ostart_ff, ostart_in;
   logic [CW-1:0]  ofree_ff, ofree_in;
   logic [CW-1:0]  oused_ff, oused_in;

   logic [CW-1:0]  eff;
   logic           req_take;
   logic [AW-1:0]  raddr;
   logic           we;
   logic [AW-1:0]  waddr;
   logic [WB-1:0]  wdata;
   logic [WB-1:0]  mask;
   logic [BW-1:0]  lo, hi;
   logic [CW:0]    pos_wide, run_wide;
   logic           bit_used;
   logic           cfg_sel;
   logic           cfg_wr;

   // clamp the total to the map size
   assign eff = (total_ff > CW'(bpa_pkg::MAX_PAGES)) ? CW'(bpa_pkg::MAX_PAGES) : total_ff;

   assign req_stall = (state_ff != bpa_pkg::S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // configuration port, decoded on the word address
   assign pready  = 1'b1;
   assign cfg_sel = ({paddr[2], 2'b00} == bpa_pkg::REG_TOTAL);
   assign cfg_wr  = psel && penable && pwrite;
   assign prdata  = cfg_sel ? {{(32-CW){1'b0}}, total_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cfg_wr && cfg_sel) begin
         total_ff <= pwdata[CW-1:0];
      end
   end

   // memory port selection
   always_comb begin
      unique case (state_ff)
         bpa_pkg::S_MRD: raddr = mw_ff;
         bpa_pkg::S_PRD: raddr = page_ff[PW-1:BW];
         default:        raddr = pos_ff[PW-1:BW];
      endcase
   end

   // span of the run inside the current word
   assign lo = (mw_ff == first_ff[PW-1:BW]) ? first_ff[BW-1:0] : '0;
   assign hi = (mw_ff == last_ff[PW-1:BW])  ? last_ff[BW-1:0]  : '1;
   always_comb begin
      for (int k = 0; k < WB; k++) begin
         mask[k] = (BW'(k) >= lo) && (BW'(k) <= hi);
      end
   end

   always_comb begin
      we    = 1'b0;
      waddr = init_ff;
      wdata = '1;
      unique case (state_ff)
         bpa_pkg::S_INIT: we = 1'b1;
         bpa_pkg::S_MWR: begin
            we    = 1'b1;
            waddr = mw_ff;
            wdata = rdata_ff | mask;
         end
         bpa_pkg::S_PWR: begin
            waddr = page_ff[PW-1:BW];
            we    = (rdata_ff[page_ff[BW-1:0]] != (op_ff == bpa_pkg::OP_RESERVE));
            wdata = rdata_ff;
            wdata[page_ff[BW-1:0]] = (op_ff == bpa_pkg::OP_RESERVE);
         end
         default: we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign pos_wide = {1'b0, pos_ff} + (CW+1)'(WB);
   assign run_wide = {1'b0, run_ff} + (CW+1)'(WB);
   assign bit_used = rdata_ff[pos_ff[BW-1:0]];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      init_in   = init_ff;
      free_in   = free_ff;
      op_in     = op_ff;
      page_in   = page_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      run_in    = run_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      mw_in     = mw_ff;
      st_in     = st_ff;
      start_in  = start_ff;
      rv_in     = rv_ff && rsp_stall;
      ost_in    = ost_ff;
      ostart_in = ostart_ff;
      ofree_in  = ofree_ff;
      oused_in  = oused_ff;
      unique case (state_ff)
         bpa_pkg::S_INIT: begin
            init_in = init_ff + 1'b1;
            if (init_ff == AW'(bpa_pkg::MAP_WORDS - 1)) begin
               state_in = bpa_pkg::S_IDLE;
            end
         end
         bpa_pkg::S_IDLE: begin
            if (req_take) begin
               op_in    = req_op;
               page_in  = req_page;
               cnt_in   = (req_op == bpa_pkg::OP_ALLOC) ? CW'(1) : req_count;
               pos_in   = '0;
               run_in   = '0;
               start_in = '0;
               st_in    = bpa_pkg::ST_OK;
               if (eff == '0) begin
                  st_in    = bpa_pkg::ST_NOT_INIT;
                  state_in = bpa_pkg::S_DONE;
               end else if (req_op == bpa_pkg::OP_ALLOC || req_op == bpa_pkg::OP_RUN) begin
                  if (req_op == bpa_pkg::OP_RUN && req_count == '0) begin
                     st_in    = bpa_pkg::ST_NO_SPACE;
                     state_in = bpa_pkg::S_DONE;
                  end else begin
                     state_in = bpa_pkg::S_SRD;
                  end
               end else if ({1'b0, req_page} >= eff) begin
                  st_in    = bpa_pkg::ST_RANGE;
                  state_in = bpa_pkg::S_DONE;
               end else begin
                  state_in = bpa_pkg::S_PRD;
               end
            end
         end
         bpa_pkg::S_SRD: state_in = bpa_pkg::S_SBIT;
         bpa_pkg::S_SBIT: begin
            priority if (pos_ff >= eff) begin
               st_in    = bpa_pkg::ST_NO_SPACE;
               state_in = bpa_pkg::S_DONE;
            end else if (pos_ff[BW-1:0] == '0 && rdata_ff == '1) begin
               // skip a fully used word
               run_in   = '0;
               pos_in   = pos_wide[CW-1:0];
               state_in = bpa_pkg::S_SRD;
            end else if (pos_ff[BW-1:0] == '0 && rdata_ff == '0 &&
                         pos_wide <= {1'b0, eff} && run_wide < {1'b0, cnt_ff}) begin
               // take a fully free word into the run
               if (run_ff == '0) first_in = pos_ff[PW-1:0];
               run_in   = run_wide[CW-1:0];
               pos_in   = pos_wide[CW-1:0];
               state_in = bpa_pkg::S_SRD;
            end else begin
               pos_in = pos_ff + 1'b1;
               if (pos_ff[BW-1:0] == '1) state_in = bpa_pkg::S_SRD;
               if (bit_used) begin
                  run_in = '0;
               end else begin
                  if (run_ff == '0) first_in = pos_ff[PW-1:0];
                  run_in = run_ff + 1'b1;
                  if (run_ff + 1'b1 == cnt_ff) begin
                     last_in  = pos_ff[PW-1:0];
                     start_in = (run_ff == '0) ? pos_ff[PW-1:0] : first_ff;
                     mw_in    = (run_ff == '0) ? pos_ff[PW-1:BW] : first_ff[PW-1:BW];
                     free_in  = free_ff - cnt_ff;
                     state_in = bpa_pkg::S_MRD;
                  end
               end
            end
         end
         bpa_pkg::S_MRD: state_in = bpa_pkg::S_MWR;
         bpa_pkg::S_MWR: begin
            // mark one word of the run, advance to the next
            mw_in = mw_ff + 1'b1;
            if (mw_ff == last_ff[PW-1:BW]) begin
               state_in = bpa_pkg::S_DONE;
            end else begin
               state_in = bpa_pkg::S_MRD;
            end
            first_in = first_ff;
         end
         bpa_pkg::S_PRD: state_in = bpa_pkg::S_PWR;
         bpa_pkg::S_PWR: begin
            if (!we) begin
               st_in = bpa_pkg::ST_NO_CHANGE;
            end else if (op_ff == bpa_pkg::OP_RESERVE) begin
               free_in = free_ff - 1'b1;
            end else begin
               free_in = free_ff + 1'b1;
            end
            state_in = bpa_pkg::S_DONE;
         end
         bpa_pkg::S_DONE: begin
            // hand the result to the output register once it is free
            if (!rv_ff || !rsp_stall) begin
               rv_in     = 1'b1;
               ost_in    = st_ff;
               ostart_in = start_ff;
               ofree_in  = free_ff;
               oused_in  = (eff > free_ff) ? eff - free_ff : '0;
               state_in  = bpa_pkg::S_IDLE;
            end
         end
         default: state_in = bpa_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::S_INIT;
         init_ff  <= '0;
         free_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         free_ff  <= free_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      page_ff   <= page_in;
      cnt_ff    <= cnt_in;
      pos_ff    <= pos_in;
      run_ff    <= run_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      mw_ff     <= mw_in;
      st_ff     <= st_in;
      start_ff  <= start_in;
      ost_ff    <= ost_in;
      ostart_ff <= ostart_in;
      ofree_ff  <= ofree_in;
      oused_ff  <= oused_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = ost_ff;
   assign rsp_first_page = ostart_ff;
   assign rsp_free_count = ofree_ff;
   assign rsp_used_count = oused_ff;

   // checks
   a_no_take_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpa_pkg::S_INIT) |-> req_stall)
      else $error("request taken during bitmap fill");

   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      free_ff <= CW'(bpa_pkg::MAX_PAGES))
      else $error("free count beyond map size");

   a_mark_after_fit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpa_pkg::S_SBIT && state_in == bpa_pkg::S_MRD) |=> (run_ff == cnt_ff))
      else $error("marking started without a full run");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpa_pkg::S_DONE && !rsp_stall) |=> (rsp_valid && state_ff == bpa_pkg::S_IDLE))
      else $error("result not loaded");

endmodule

>>> sim/bpa_checker.sv
`timescale 1ns / 1ps
module bpa_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [bpa_pkg::PAGE_W-1:0]   req_page,
   input  logic [bpa_pkg::CNT_W-1:0]    req_count,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [bpa_pkg::STAT_W-1:0]   rsp_status,
   input  logic [bpa_pkg::PAGE_W-1:0]   rsp_first_page,
   input  logic [bpa_pkg::CNT_W-1:0]    rsp_free_count,
   input  logic [bpa_pkg::CNT_W-1:0]    rsp_used_count,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   input  logic                         pready,
   output int                           fail_count,
   output int                           pending
);

   typedef struct packed {
      logic [bpa_pkg::STAT_W-1:0] status;
      logic [bpa_pkg::PAGE_W-1:0] first_page;
      logic [bpa_pkg::CNT_W-1:0]  free_count;
      logic [bpa_pkg::CNT_W-1:0]  used_count;
   } alloc_result_type;

   bit            page_used [0:bpa_pkg::MAX_PAGES-1];
   int unsigned   free_cnt;
   logic [bpa_pkg::CNT_W-1:0] total_reg;
   alloc_result_type awaited_q [$];

   // Work out the answer of one allocator operation and update the shadow map
   function automatic alloc_result_type allocate_step(logic [1:0] op, int unsigned page,
                                                      int unsigned count);
      alloc_result_type r;
      int unsigned   lim;
      int unsigned   run;
      int unsigned   first;
      bit            done;
      bit            want_used;
      lim = (total_reg > bpa_pkg::MAX_PAGES) ? bpa_pkg::MAX_PAGES : total_reg;
      r.status = bpa_pkg::ST_OK;
      r.first_page = '0;
      run = 0;
      first = 0;
      done = 0;
      if (lim == 0) begin
         r.status = bpa_pkg::ST_NOT_INIT;
      end else if (op == bpa_pkg::OP_ALLOC) begin
         r.status = bpa_pkg::ST_NO_SPACE;
         for (int unsigned i = 0; i < lim && !done; i++) begin
            if (!page_used[i]) begin
               page_used[i] = 1;
               free_cnt--;
               r.first_page = i[bpa_pkg::PAGE_W-1:0];
               r.status = bpa_pkg::ST_OK;
               done = 1;
            end
         end
      end else if (op == bpa_pkg::OP_RUN) begin
         r.status = bpa_pkg::ST_NO_SPACE;
         if (count != 0) begin
            for (int unsigned i = 0; i < lim && !done; i++) begin
               if (page_used[i]) begin
                  run = 0;
               end else begin
                  if (run == 0) first = i;
                  run++;
                  if (run == count) begin
                     for (int unsigned j = first; j <= i; j++) page_used[j] = 1;
                     free_cnt -= count;
                     r.first_page = first[bpa_pkg::PAGE_W-1:0];
                     r.status = bpa_pkg::ST_OK;
                     done = 1;
                  end
               end
            end
         end
      end else begin
         want_used = (op == bpa_pkg::OP_RESERVE);
         if (page >= lim) begin
            r.status = bpa_pkg::ST_RANGE;
         end else if (page_used[page] == want_used) begin
            r.status = bpa_pkg::ST_NO_CHANGE;
         end else begin
            page_used[page] = want_used;
            if (want_used) free_cnt--;
            else free_cnt++;
         end
      end
      r.free_count = free_cnt[bpa_pkg::CNT_W-1:0];
      r.used_count = (lim > free_cnt) ? bpa_pkg::CNT_W'(lim - free_cnt) : '0;
      return r;
   endfunction

   // Track register writes, predict on request transfers, compare on result transfers
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         foreach (page_used[i]) page_used[i] = 1;
         free_cnt = 0;
         total_reg = '0;
         awaited_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            total_reg = pwdata[bpa_pkg::CNT_W-1:0];
         if (req_valid && !req_stall)
            awaited_q.push_back(allocate_step(req_op, req_page, req_count));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_q.size() == 0) begin
               $error("result transfer with nothing awaited");
               fail_count <= fail_count + 1;
            end else begin
               want = awaited_q.pop_front();
               if (rsp_status !== want.status ||
                   rsp_first_page !== want.first_page ||
                   rsp_free_count !== want.free_count ||
                   rsp_used_count !== want.used_count)
                  fail_count <= fail_count + 1;
               if (rsp_status !== want.status)
                  $error("status expected %0d actual %0d", want.status, rsp_status);
               if (rsp_first_page !== want.first_page)
                  $error("first_page expected %0d actual %0d", want.first_page,
                         rsp_first_page);
               if (rsp_free_count !== want.free_count)
                  $error("free_count expected %0d actual %0d", want.free_count,
                         rsp_free_count);
               if (rsp_used_count !== want.used_count)
                  $error("used_count expected %0d actual %0d", want.used_count,
                         rsp_used_count);
            end
         end
         pending <= awaited_q.size();
      end
   end

endmodule

>>> sim/bitmap_page_allocator_core_tb.sv
`timescale 1ns / 1ps
module bitmap_page_allocator_core_tb;

   localparam int STALL_LIMIT = 500000;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [1:0]                   req_op;
   logic [bpa_pkg::PAGE_W-1:0]   req_page;
   logic [bpa_pkg::CNT_W-1:0]    req_count;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [bpa_pkg::STAT_W-1:0]   rsp_status;
   logic [bpa_pkg::PAGE_W-1:0]   rsp_first_page;
   logic [bpa_pkg::CNT_W-1:0]    rsp_free_count;
   logic [bpa_pkg::CNT_W-1:0]    rsp_used_count;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [2:0]                   paddr;
   logic [31:0]                  pwdata;
   logic [31:0]                  prdata;
   logic                         pready;

   int          fail_count;
   int          pending;
   int          idle_pct;
   int          stall_pct;
   int unsigned cur_total;
   int          quiet_cycles;

   bitmap_page_allocator_core DUT (.*);

   bpa_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver back-pressure at the phase's rate
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watchdog: give up after a long stretch with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one operation and hold it until the transfer
   task automatic send_op(logic [1:0] op, int unsigned page, int unsigned count);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_page  <= page[bpa_pkg::PAGE_W-1:0];
      req_count <= count[bpa_pkg::CNT_W-1:0];
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
   endtask

   // Wait until every awaited result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Write the page total over the register port while the block is idle
   task automatic write_total(int unsigned value);
      drain();
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= bpa_pkg::REG_TOTAL;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_total = value;
   endtask

   // Random operation biased towards in-range pages and short runs
   task automatic send_random();
      int unsigned lim;
      int unsigned pick;
      int unsigned page;
      int unsigned count;
      logic [1:0]  op;
      lim  = (cur_total > bpa_pkg::MAX_PAGES) ? bpa_pkg::MAX_PAGES : cur_total;
      pick = $urandom_range(0, 99);
      op   = (pick < 35) ? bpa_pkg::OP_FREE : (pick < 60) ? bpa_pkg::OP_ALLOC :
             (pick < 85) ? bpa_pkg::OP_RUN : bpa_pkg::OP_RESERVE;
      if ($urandom_range(0, 99) < 85)
         page = $urandom_range(0, (lim + 3 > bpa_pkg::MAX_PAGES - 1) ?
                                  bpa_pkg::MAX_PAGES - 1 : lim + 3);
      else
         page = $urandom & 17'h1FFFF;
      pick = $urandom_range(0, 99);
      if (pick < 70) count = $urandom_range(0, 6);
      else if (pick < 90) count = $urandom_range(0, lim + 2);
      else count = $urandom & 18'h3FFFF;
      send_op(op, page, count);
   endtask

   task automatic run_phase(int items, int idle, int stall);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (items) send_random();
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_op    <= bpa_pkg::OP_ALLOC;
      req_page  <= '0;
      req_count <= '0;
      rsp_stall <= 1'b0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= bpa_pkg::REG_TOTAL;
      pwdata    <= '0;
      idle_pct  = 0;
      stall_pct = 0;
      cur_total = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Not initialised: every operation refused
      send_op(bpa_pkg::OP_ALLOC, 0, 0);
      send_op(bpa_pkg::OP_RUN, 0, 1);
      send_op(bpa_pkg::OP_FREE, 0, 0);
      send_op(bpa_pkg::OP_RESERVE, 0, 0);

      // Small map: full map, double free, runs too long, range checks
      write_total(16);
      send_op(bpa_pkg::OP_ALLOC, 0, 0);
      send_op(bpa_pkg::OP_FREE, 3, 0);
      send_op(bpa_pkg::OP_FREE, 3, 0);
      send_op(bpa_pkg::OP_FREE, 4, 0);
      send_op(bpa_pkg::OP_FREE, 5, 0);
      send_op(bpa_pkg::OP_FREE, 6, 0);
      send_op(bpa_pkg::OP_RUN, 0, 0);
      send_op(bpa_pkg::OP_RUN, 0, 5);
      send_op(bpa_pkg::OP_RUN, 0, 4);
      send_op(bpa_pkg::OP_FREE, 15, 0);
      send_op(bpa_pkg::OP_ALLOC, 0, 0);
      send_op(bpa_pkg::OP_RESERVE, 20, 0);
      send_op(bpa_pkg::OP_RESERVE, 131071, 0);
      send_op(bpa_pkg::OP_FREE, 2, 0);
      send_op(bpa_pkg::OP_RESERVE, 2, 0);
      send_op(bpa_pkg::OP_RESERVE, 2, 0);
      send_op(bpa_pkg::OP_RUN, 0, 262143);
      send_op(bpa_pkg::OP_FREE, 10, 0);
      send_op(bpa_pkg::OP_FREE, 11, 0);

      // Lowered total: free pages beyond it stay counted, used saturates
      write_total(1);
      send_op(bpa_pkg::OP_ALLOC, 0, 0);
      send_op(bpa_pkg::OP_FREE, 0, 0);

      // Random phases over several totals and idling patterns
      write_total(200);
      run_phase(280, 0, 0);
      write_total(64);
      run_phase(200, 59, 0);
      drain();
      run_phase(60, 59, 0);
      write_total(262143);
      run_phase(100, 0, 59);
      write_total(0);
      run_phase(20, 7, 7);
      write_total(131072);
      run_phase(60, 7, 7);
      write_total(1000);
      run_phase(300, 7, 7);
      write_total(200);
      run_phase(80, 0, 59);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         if (pending != 0) $error("%0d results never arrived", pending);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/bpa_pkg.sv
rtl/bitmap_page_allocator_core.sv
sim/bpa_checker.sv
sim/bitmap_page_allocator_core_tb.sv
